>>> src/postfix_stack_evaluator_top_macros.svh
// Assertion macros shared by the postfix stack evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/pse_pkg.sv
// Shared types, codes and helpers for the postfix stack evaluator.
package pse_pkg;

    localparam int DATA_W  = 32;              // Q16.16 word
    localparam int FRAC_W  = 16;
    localparam int OPC_W   = 3;
    localparam int STAT_W  = 3;
    localparam int DEPTH_W = 6;               // depth field of a result
    localparam int PROD_W  = 2 * DATA_W;      // full product
    localparam int DIV_W   = DATA_W + FRAC_W; // dividend / quotient magnitude
    localparam int WIDE_W  = DIV_W + 1;       // signed wide value before saturation

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [OPC_W-1:0] {
        OPC_PUSH = 3'd0,
        OPC_ADD  = 3'd1,
        OPC_SUB  = 3'd2,
        OPC_MUL  = 3'd3,
        OPC_DIV  = 3'd4,
        OPC_END  = 3'd5
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_DIVZ  = 3'd2,
        ST_OVER  = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_FILL,
        S_DONE
    } t_seq_state;

    typedef enum logic [1:0] {
        AL_IDLE,
        AL_MULFIN,
        AL_DIV,
        AL_DIVFIN
    } t_alu_state;

    typedef struct packed {
        logic    start;
        t_opcode op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic divz;
    } t_alu_rsp;

    // Clamp a signed wide value into the 32-bit range
    function automatic logic [DATA_W-1:0] sat_q16(input logic signed [WIDE_W-1:0] v);
        logic fits;
        fits = (&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]);
        if (fits) begin
            return v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

endpackage

>>> src/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/pse_alu.sv
// Shared Q16.16 arithmetic unit: saturating add/sub, two-step multiply,
// bit-serial restoring divide.
module pse_alu
    import pse_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_alu_req                 i_req,
    input  logic signed [DATA_W-1:0] i_a,      // top of stack
    input  logic signed [DATA_W-1:0] i_b,      // entry below top
    output t_alu_rsp                 o_rsp,
    output logic [DATA_W-1:0]        o_result
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    t_alu_state r_state, n_state;
    logic       r_done, n_done;
    logic       r_divz, n_divz;

    logic [DATA_W-1:0]        r_res;
    logic signed [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0]        r_rem;
    logic [DIV_W-1:0]         r_dvd;
    logic [DIV_W-1:0]         r_q;
    logic [DATA_W-1:0]        r_dvs;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_cnt;

    logic signed [DATA_W:0]   sum_ext;
    logic [DATA_W-1:0]        a_mag, b_mag;
    logic [WIDE_W-2:0]        prod_sh;
    logic                     prod_rnd;
    logic signed [WIDE_W-1:0] mul_wide;
    logic [DATA_W:0]          rem_sh;
    logic [DATA_W:0]          rem_sub;
    logic                     rem_ge;
    logic [WIDE_W-1:0]        q_ext;
    logic signed [WIDE_W-1:0] div_wide;

    // Operand preparation and single-step arithmetic
    always_comb begin
        if (i_req.op == OPC_SUB) begin
            sum_ext = {i_b[DATA_W-1], i_b} - {i_a[DATA_W-1], i_a};
        end else begin
            sum_ext = {i_b[DATA_W-1], i_b} + {i_a[DATA_W-1], i_a};
        end
        a_mag = i_a[DATA_W-1] ? DATA_W'(-i_a) : i_a;
        b_mag = i_b[DATA_W-1] ? DATA_W'(-i_b) : i_b;

        // product / 2^16, truncated toward zero
        prod_sh  = r_prod[PROD_W-1:FRAC_W];
        prod_rnd = r_prod[PROD_W-1] && (r_prod[FRAC_W-1:0] != '0);
        mul_wide = $signed({prod_sh[WIDE_W-2], prod_sh}) + $signed({{(WIDE_W-1){1'b0}}, prod_rnd});

        // one restoring division step
        rem_sh  = {r_rem, r_dvd[DIV_W-1]};
        rem_ge  = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};

        q_ext    = {1'b0, r_q};
        div_wide = r_neg ? $signed(-q_ext) : $signed(q_ext);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_divz  = 1'b0;
        case (r_state)
            AL_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        OPC_ADD, OPC_SUB: n_done = 1'b1;
                        OPC_MUL:          n_state = AL_MULFIN;
                        OPC_DIV: begin
                            if (i_a == '0) begin
                                n_done = 1'b1;
                                n_divz = 1'b1;
                            end else begin
                                n_state = AL_DIV;
                            end
                        end
                        default:          n_done = 1'b1;
                    endcase
                end
            end
            AL_MULFIN: begin
                n_done  = 1'b1;
                n_state = AL_IDLE;
            end
            AL_DIV: begin
                if (r_cnt == '0) begin
                    n_state = AL_DIVFIN;
                end
            end
            AL_DIVFIN: begin
                n_done  = 1'b1;
                n_state = AL_IDLE;
            end
            default: n_state = AL_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AL_IDLE;
            r_done  <= 1'b0;
            r_divz  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_divz  <= n_divz;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            AL_IDLE: begin
                if (i_req.start) begin
                    r_res  <= sat_q16({{(WIDE_W-DATA_W-1){sum_ext[DATA_W]}}, sum_ext});
                    r_prod <= i_b * i_a;
                    r_rem  <= '0;
                    r_dvd  <= {b_mag, {FRAC_W{1'b0}}};
                    r_q    <= '0;
                    r_dvs  <= a_mag;
                    r_neg  <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                    r_cnt  <= LAST_STEP;
                end
            end
            AL_MULFIN: r_res <= sat_q16(mul_wide);
            AL_DIV: begin
                r_rem <= rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], rem_ge};
                r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            AL_DIVFIN: r_res <= sat_q16(div_wide);
            default: r_res <= r_res;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.divz = r_divz;
    assign o_result   = r_res;

endmodule

>>> src/postfix_stack_evaluator_top.sv
// Top level of the postfix stack evaluator: stack sequencer, stack RAM and shared ALU.
//
//  Channel   Dir  Signals                 Contents (low bits first)
//  command   in   i_s_tvalid/o_s_tready   tuser: opcode[2:0]; tdata: operand_value[31:0]
//  result    out  o_m_tvalid/i_m_tready   tuser: status[2:0];
//                                         tdata: result_value[31:0], depth[37:32], pad
//
//  One command at a time. Push, end, short operators and unknown opcodes finish
//  without the ALU; end refills the top register when entries remain below it.
//  Divide: the shared ALU resolves one quotient bit per cycle over a 48-bit
//  dividend. Divide by zero stops early, with a refill when entries remain.
//  The top of stack lives in a register; the single-read-port RAM holds the rest.
//  Reset (synchronous, active low) empties the stack; no RAM clearing pass.
//  A finished result waits in the output register while the next command is taken.
`include "postfix_stack_evaluator_top_macros.svh"

module postfix_stack_evaluator_top
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [OPC_W-1:0]   i_s_tuser,   // [2:0] opcode
    input  logic [DATA_W-1:0]  i_s_tdata,   // [31:0] operand_value
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [STAT_W-1:0]  o_m_tuser,   // [2:0] status
    output logic [39:0]        o_m_tdata    // [31:0] result_value, [37:32] depth, zero pad
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

    t_seq_state        r_state, n_state;
    t_opcode           r_op, n_op;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_top, n_top;
    logic [DATA_W-1:0] r_res, n_res;
    t_status           r_status, n_status;

    logic               r_m_valid;
    logic [DATA_W-1:0]  r_m_result;
    t_status            r_m_status;
    logic [DEPTH_W-1:0] r_m_depth;

    logic              s_fire;
    logic              out_load;
    t_opcode           opc_in;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2, cnt_m3;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic [DATA_W-1:0] alu_result;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign opc_in     = t_opcode'(i_s_tuser);
    assign cnt_m1     = r_count - CNT_W'(1);
    assign cnt_m2     = r_count - CNT_W'(2);
    assign cnt_m3     = r_count - CNT_W'(3);
    assign out_load   = (r_state == S_DONE) && (!r_m_valid || i_m_tready);

    // Entries below the top of stack
    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Shared arithmetic unit
    pse_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_top),
        .i_b      (ram_rd_data),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    // Sequencer: next state, stack update, RAM and ALU controls
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_count     = r_count;
        n_top       = r_top;
        n_res       = r_res;
        n_status    = r_status;
        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_m1[ADDR_W-1:0];
        ram_wr_data = r_top;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cnt_m2[ADDR_W-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_op     = opc_in;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    case (opc_in)
                        OPC_PUSH: begin
                            if (r_count == FULL) begin
                                n_status = ST_OVER;
                                n_res    = r_top;
                            end else begin
                                // spill the old top below the new one
                                ram_wr_en = (r_count != '0);
                                n_top     = i_s_tdata;
                                n_res     = i_s_tdata;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV: begin
                            if (r_count < CNT_W'(2)) begin
                                n_status = ST_UNDER;
                                n_res    = (r_count != '0) ? r_top : '0;
                            end else begin
                                ram_rd_en = 1'b1;
                                n_state   = S_READ;
                            end
                        end
                        OPC_END: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_res    = '0;
                            end else begin
                                n_res   = r_top;
                                n_count = cnt_m1;
                                if (r_count >= CNT_W'(2)) begin
                                    ram_rd_en = 1'b1;
                                    n_state   = S_FILL;
                                end
                            end
                        end
                        default: n_res = (r_count != '0) ? r_top : '0;
                    endcase
                end
            end
            S_READ: begin
                // second operand is on the RAM read port now
                alu_req.start = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                if (alu_rsp.done) begin
                    if (alu_rsp.divz) begin
                        n_status = ST_DIVZ;
                        n_count  = cnt_m2;
                        if (r_count >= CNT_W'(3)) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = cnt_m3[ADDR_W-1:0];
                            n_state     = S_FILL;
                        end else begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_top   = alu_result;
                        n_res   = alu_result;
                        n_count = cnt_m1;
                        n_state = S_DONE;
                    end
                end
            end
            S_FILL: begin
                // refill the top register after a pop
                n_top = ram_rd_data;
                if (r_op != OPC_END) begin
                    n_res = ram_rd_data;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer and stack registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_top    <= n_top;
        r_res    <= n_res;
        r_status <= n_status;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (out_load) begin
            r_m_result <= r_res;
            r_m_status <= r_status;
            r_m_depth  <= DEPTH_W'(r_count);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = {2'b00, r_m_depth, r_m_result};

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_fire, r_state != S_IDLE)
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `ASSERT_IMPL(a_alu_done_in_exec, i_clk, i_rst_n, alu_rsp.done, r_state == S_EXEC)

endmodule
